// ===== design/mm3_pkg.sv =====
// Shared types, constants and controller/datapath interface for the string hash block.
package mm3_pkg;

  localparam logic [31:0] SeedReset = 32'h2908_48ab;
  localparam logic [31:0] MixC1     = 32'hcc9e_2d51;
  localparam logic [31:0] MixC2     = 32'h1b87_3593;
  localparam logic [31:0] MixN      = 32'he654_6b64;
  localparam logic [31:0] FinF1     = 32'h85eb_ca6b;
  localparam logic [31:0] FinF2     = 32'hc2b2_ae35;
  localparam logic [30:0] CountMax  = 31'h7fff_ffff;
  localparam logic [1:0]  LaneLast  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [30:0] message_length;
  } out_item_t;

  typedef enum logic [1:0] {
    MUL_K_C1,
    MUL_K_C2,
    MUL_F1,
    MUL_F2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     mix_blk;
    logic     mix_tail;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_byte;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/mm3_dp.sv =====
// Datapath of the string hash block: message state, shared multiplier and output register.
module mm3_dp import mm3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  logic [31:0] seed_q;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [23:0] partial_q, partial_d;
  logic [30:0] count_q, count_d;
  logic [1:0]  lane_q, lane_d;
  logic        zero_q, zero_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] fin_t, mix_x, mix_r, fin_h;
  logic [23:0] partial_new;
  logic        first;
  logic [7:0]  b;

  assign b     = in_data_i.data_byte;
  assign first = (count_q == '0);
  assign fin_t = h_q ^ {1'b0, count_q};

  always_comb begin
    mul_a = k_q;
    mul_b = MixC1;
    case (cmd_i.mul_sel)
      MUL_K_C1: begin
        mul_a = k_q;
        mul_b = MixC1;
      end
      MUL_K_C2: begin
        mul_a = {k_q[16:0], k_q[31:17]};
        mul_b = MixC2;
      end
      MUL_F1: begin
        mul_a = fin_t ^ (fin_t >> 16);
        mul_b = FinF1;
      end
      MUL_F2: begin
        mul_a = k_q ^ (k_q >> 13);
        mul_b = FinF2;
      end
      default: begin
        mul_a = k_q;
        mul_b = MixC1;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign mix_x = h_q ^ k_q;
  assign mix_r = {mix_x[18:0], mix_x[31:19]};
  assign fin_h = k_q ^ (k_q >> 16);

  always_comb begin
    partial_new = partial_q;
    case (lane_q)
      2'd0:    partial_new[7:0]   = b;
      2'd1:    partial_new[15:8]  = b;
      2'd2:    partial_new[23:16] = b;
      default: partial_new        = partial_q;
    endcase
  end

  always_comb begin
    h_d         = h_q;
    k_d         = k_q;
    partial_d   = partial_q;
    count_d     = count_q;
    lane_d      = lane_q;
    zero_d      = zero_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      h_d     = first ? seed_q : h_q;
      zero_d  = first ? (b == 8'd0) : zero_q;
      count_d = (count_q == CountMax) ? count_q : count_q + 31'd1;
      lane_d  = lane_q + 2'd1;
      if (lane_q == LaneLast) begin
        k_d       = {b, partial_q};
        partial_d = '0;
      end else begin
        k_d       = {8'd0, partial_new};
        partial_d = partial_new;
      end
    end
    if (cmd_i.mul_en) begin
      k_d = prod;
    end
    if (cmd_i.mix_blk) begin
      h_d = (mix_r << 2) + mix_r + MixN;
    end
    if (cmd_i.mix_tail) begin
      h_d = mix_x;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (zero_q) begin
        out_d.hash_value     = '0;
        out_d.message_length = '0;
      end else begin
        out_d.hash_value     = fin_h;
        out_d.message_length = count_q;
      end
      h_d       = seed_q;
      partial_d = '0;
      count_d   = '0;
      lane_d    = '0;
      zero_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedReset;
      h_q         <= SeedReset;
      partial_q   <= '0;
      count_q     <= '0;
      lane_q      <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      h_q         <= h_d;
      partial_q   <= partial_d;
      count_q     <= count_d;
      lane_q      <= lane_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    out_q <= out_d;
  end

  assign status_o.blk_byte = (lane_q == LaneLast);
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// ===== design/mm3_ctrl.sv =====
// Controller of the string hash block: sequences block mixing, tail folding and finalisation.
module mm3_ctrl import mm3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MIXB,
    ST_MIXT,
    ST_FIN1,
    ST_FIN2,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   block_q, block_d;
  logic   last_q, last_d;

  always_comb begin
    state_d       = state_q;
    block_d       = block_q;
    last_d        = last_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_K_C1;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          block_d    = status_i.blk_byte;
          last_d     = in_last_i;
          if (status_i.blk_byte || in_last_i) begin
            state_d = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_K_C1;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_K_C2;
        state_d       = block_q ? ST_MIXB : ST_MIXT;
      end
      ST_MIXB: begin
        cmd_o.mix_blk = 1'b1;
        state_d       = last_q ? ST_FIN1 : ST_IDLE;
      end
      ST_MIXT: begin
        cmd_o.mix_tail = 1'b1;
        state_d        = ST_FIN1;
      end
      ST_FIN1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_F1;
        state_d       = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_F2;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      block_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      block_q <= block_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== design/murmur3_32_string_hash.sv =====
// Top level of the 32-bit string hash block over a byte stream.
//
//   Channel | Handshake                    | Payload
//   --------+------------------------------+----------------------------------
//   in      | in_valid_i / in_stall_o      | in_data_i  (data_byte, last_byte)
//   out     | out_valid_o / out_stall_i    | out_data_o (hash_value, length)
//   cfg     | cfg_we_i                     | cfg_wdata_i (seed)
//
// A byte that closes no block or message is only loaded in ST_IDLE; a 4-byte block's
// last byte then runs MUL1, MUL2, MIXB, and the message's last byte MUL1, MUL2, MIXB or
// MIXT, FIN1, FIN2, EMIT (which waits for the output), on one shared 32x32 multiplier.
// After reset the seed and message state are loaded; no clearing pass is needed.
// The result waits in an output register, and further bytes are taken while it is stalled.
module murmur3_32_string_hash import mm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mm3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_byte),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mm3_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the byte-stream 32-bit string hash block.
module tb;
  import mm3_pkg::*;

  localparam logic [31:0] K_C1        = 32'hcc9e_2d51;
  localparam logic [31:0] K_C2        = 32'h1b87_3593;
  localparam logic [31:0] K_N         = 32'he654_6b64;
  localparam logic [31:0] K_F1        = 32'h85eb_ca6b;
  localparam logic [31:0] K_F2        = 32'hc2b2_ae35;
  localparam int          GAP_PCT     = 26;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AFTER  = 250;
  localparam int          TAIL_CYCLES = 12;
  localparam int          STUCK_LIMIT = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  murmur3_32_string_hash DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  in_item_t  pending_bytes[$];
  out_item_t expected_digests[$];

  logic [31:0] seed_model = 32'h2908_48ab;
  logic [31:0] run_hash   = 32'h2908_48ab;
  logic [23:0] tail_word  = '0;
  logic [30:0] byte_total = '0;
  logic [1:0]  lane_pos   = '0;
  logic        zero_lead  = 1'b0;

  bit in_took     = 1'b0;
  bit gapless     = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;
  int bytes_in    = 0;
  int msgs_queued = 0;
  int hashes_seen = 0;
  int errors      = 0;
  int stuck       = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] v;
    v = k * K_C1;
    v = rotl32(v, 15);
    return v * K_C2;
  endfunction

  task automatic absorb_byte(input in_item_t it);
    logic [31:0] h;
    out_item_t   res;
    if (byte_total == '0) begin
      h = seed_model;
      zero_lead = (it.data_byte == 8'h00);
    end else begin
      h = run_hash;
    end
    if (lane_pos == 2'd3) begin
      h ^= scramble_block({it.data_byte, tail_word});
      h = rotl32(h, 13);
      h = h * 32'd5 + K_N;
      tail_word = '0;
    end else begin
      tail_word = tail_word | (24'(it.data_byte) << (8 * lane_pos));
    end
    lane_pos = lane_pos + 2'd1;
    if (byte_total != '1) begin
      byte_total = byte_total + 31'd1;
    end
    run_hash = h;
    if (it.last_byte) begin
      if (lane_pos != 2'd0) begin
        h ^= scramble_block({8'h00, tail_word});
      end
      h ^= {1'b0, byte_total};
      h ^= h >> 16;
      h = h * K_F1;
      h ^= h >> 13;
      h = h * K_F2;
      h ^= h >> 16;
      if (zero_lead) begin
        res = '0;
      end else begin
        res.hash_value     = h;
        res.message_length = byte_total;
      end
      expected_digests.push_back(res);
      run_hash   = seed_model;
      tail_word  = '0;
      byte_total = '0;
      lane_pos   = '0;
      zero_lead  = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    pending_bytes.push_back(it);
    if (last) begin
      msgs_queued++;
    end
  endtask

  task automatic queue_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      if (i == 0 && $urandom_range(11) == 0) begin
        b = 8'h00;
      end
      push_byte(b, i == len - 1);
    end
  endtask

  task automatic random_traffic(input int n_bytes);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      queue_message(len);
      sent += len;
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_digests.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_seed(input logic [31:0] v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(negedge clk_i) begin : drive_bytes
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid_i && in_took) begin
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_bytes.size() != 0 &&
          (gapless || $urandom_range(99) >= GAP_PCT)) begin
        nxt_data  = pending_bytes.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && bytes_in >= HOLD_AFTER) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !gapless && ($urandom_range(99) < GAP_PCT);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    out_item_t want;
    bit        out_took;
    in_took  = rst_ni && in_valid_i && !in_stall_o;
    out_took = rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && cfg_we_i) begin
      seed_model = cfg_wdata_i;
    end
    if (in_took) begin
      bytes_in++;
      absorb_byte(in_data_i);
    end
    if (out_took) begin
      hashes_seen++;
      if (expected_digests.size() == 0) begin
        report_mismatch("unexpected result, hash", out_data_o.hash_value, '0);
      end else begin
        want = expected_digests.pop_front();
        if (out_data_o.hash_value !== want.hash_value) begin
          report_mismatch("hash_value", out_data_o.hash_value, want.hash_value);
        end
        if (out_data_o.message_length !== want.message_length) begin
          report_mismatch("message_length", {1'b0, out_data_o.message_length},
                          {1'b0, want.message_length});
        end
      end
    end
    if (in_took || out_took || cfg_we_i || !rst_ni) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", stuck);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hfe, 1'b1);
    push_byte(8'haa, 1'b0);
    push_byte(8'hbb, 1'b0);
    push_byte(8'hcc, 1'b0);
    wait_idle();
    // The new seed must only apply from the next message onwards.
    load_seed(32'h0000_0000);
    push_byte(8'hdd, 1'b0);
    push_byte(8'hee, 1'b1);
    push_byte(8'h55, 1'b1);
    wait_idle();

    random_traffic(400);
    wait_idle();
    load_seed(32'hffff_ffff);
    random_traffic(400);
    wait_idle();
    load_seed($urandom);
    random_traffic(450);
    wait_idle();
    load_seed($urandom);
    gapless = 1'b1;
    random_traffic(450);
    wait_idle();
    gapless = 1'b0;

    $display("Hashed %0d bytes in %0d messages under five seeds, with one long output hold.",
             bytes_in, msgs_queued);
    $display("Checked %0d results, %0d mismatches.", hashes_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mm3_pkg.sv
design/mm3_dp.sv
design/mm3_ctrl.sv
design/murmur3_32_string_hash.sv
tb/tb.sv
